// ===== rtl/rpa_pkg.sv =====
// Shared constants, codes and transaction types of the page allocator.
package rpa_pkg;

   localparam int NUM_PAGES  = 16384;
   localparam int COUNT_BITS = 8;

   localparam int IDX_W   = $clog2(NUM_PAGES);
   localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
   localparam int WIDE_W  = 17;

   localparam int OP_W   = 3;
   localparam int PAGE_W = 14;
   localparam int STAT_W = 2;
   localparam int REF_W  = 8;
   localparam int FREE_W = 15;

   localparam logic [OP_W-1:0] OP_INIT       = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC      = 3'd1;
   localparam logic [OP_W-1:0] OP_FREE       = 3'd2;
   localparam logic [OP_W-1:0] OP_INC_REF    = 3'd3;
   localparam logic [OP_W-1:0] OP_DEC_REF    = 3'd4;
   localparam logic [OP_W-1:0] OP_GET_REF    = 3'd5;
   localparam logic [OP_W-1:0] OP_GET_FREE   = 3'd6;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NO_PAGE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BAD_PAGE = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] page_out;
      logic [REF_W-1:0]  ref_count;
      logic [FREE_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic walk_start;
      logic walk_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic op_init;
      logic clear_last;
      logic walk_done;
   } sts_type;

endpackage

// ===== rtl/refcounted_page_allocator_unit.sv =====
// Top level of the reference-counted page allocator with its configuration register.
//
//   Channel   Direction  Handshake                     Content
//   req_      in         req_valid / req_ready         opcode and page (rpa_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready         status, page_out, ref_count, free_count
//   csr       in/out     psel, penable, pwrite, pready first_page register at byte address 0
//
// In a transaction the accept edge reads the count memory and the stack top, and the
// commit edge writes both memories back and loads the result register.
// Init walks the memories one page a cycle, from first_page up to the last page.
// After reset a clearing pass zeroes all NUM_PAGES (16384) entries of the count memory with
// req_ready low; register writes are taken throughout.
// A waiting result holds the next transaction before its write-back until the register frees.
module refcounted_page_allocator_unit (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_ready,
   input  rpa_pkg::req_type           req_data,

   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rpa_pkg::rsp_type           rsp_data,

   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam logic [2:0] ADDR_FIRST_PAGE = 3'd0;

   // The first usable page; the user must write it only while the block is idle, which the block does not enforce.
   logic [rpa_pkg::PAGE_W-1:0] first_page_ff;
   logic                       csr_write;

   rpa_pkg::cmd_type cmd;
   rpa_pkg::sts_type sts;

   // The port never inserts wait states.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr == ADDR_FIRST_PAGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else if (csr_write) begin
         first_page_ff <= pwdata[rpa_pkg::PAGE_W-1:0];
      end
   end

   // Reads of any address other than the register return zero.
   assign prdata = (paddr == ADDR_FIRST_PAGE) ? 32'(first_page_ff) : '0;

   // The controller sequences each transaction; the datapath owns all storage.
   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rpa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .first_page (first_page_ff),
      .sts        (sts),
      .rsp        (rsp_data)
   );

endmodule

// ===== rtl/rpa_datapath.sv =====
// Datapath of the page allocator: count and stack memories, depth, walk counter, result.
module rpa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rpa_pkg::cmd_type              cmd,
   input  rpa_pkg::req_type              req,
   input  logic [rpa_pkg::PAGE_W-1:0]    first_page,
   output rpa_pkg::sts_type              sts,
   output rpa_pkg::rsp_type              rsp
);

   logic [rpa_pkg::COUNT_BITS-1:0] ref_mem [rpa_pkg::NUM_PAGES];
   logic [rpa_pkg::PAGE_W-1:0]     stk_mem [rpa_pkg::NUM_PAGES];

   logic [rpa_pkg::OP_W-1:0]       op_ff;
   logic [rpa_pkg::PAGE_W-1:0]     page_ff;
   logic [rpa_pkg::COUNT_BITS-1:0] ref_rd_ff;
   logic [rpa_pkg::PAGE_W-1:0]     stk_rd_ff;
   logic [rpa_pkg::DEPTH_W-1:0]    depth_ff, depth_in;
   logic [rpa_pkg::WIDE_W-1:0]     walk_ff, walk_in;
   rpa_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           ref_we;
   logic [rpa_pkg::IDX_W-1:0]      ref_waddr;
   logic [rpa_pkg::COUNT_BITS-1:0] ref_wdata;
   logic                           stk_we;
   logic [rpa_pkg::IDX_W-1:0]      stk_waddr;
   logic [rpa_pkg::PAGE_W-1:0]     stk_wdata;
   logic [rpa_pkg::IDX_W-1:0]      ref_raddr;
   logic [rpa_pkg::IDX_W-1:0]      stk_raddr;

   logic [rpa_pkg::WIDE_W-1:0]     page_wide;
   logic [rpa_pkg::WIDE_W-1:0]     pop_wide;
   logic                           in_range;
   logic                           below_first;
   logic                           stack_full;
   logic [rpa_pkg::COUNT_BITS-1:0] inc_cnt;
   logic [rpa_pkg::COUNT_BITS-1:0] dec_cnt;

   function automatic logic [rpa_pkg::REF_W-1:0] cap_count(
      input logic [rpa_pkg::COUNT_BITS-1:0] c
   );
      if (rpa_pkg::WIDE_W'(c) > rpa_pkg::WIDE_W'(255)) begin
         return '1;
      end
      return rpa_pkg::REF_W'(c);
   endfunction

   assign ref_raddr = rpa_pkg::IDX_W'(rpa_pkg::WIDE_W'(req.page));
   assign stk_raddr = rpa_pkg::IDX_W'(depth_ff - rpa_pkg::DEPTH_W'(1));

   assign page_wide   = rpa_pkg::WIDE_W'(page_ff);
   assign pop_wide    = rpa_pkg::WIDE_W'(stk_rd_ff);
   assign in_range    = page_wide < rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES);
   assign below_first = page_ff < first_page;
   assign stack_full  = rpa_pkg::WIDE_W'(depth_ff) >= rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES);
   assign inc_cnt     = (ref_rd_ff != '1) ? ref_rd_ff + rpa_pkg::COUNT_BITS'(1) : ref_rd_ff;
   assign dec_cnt     = (ref_rd_ff != '0) ? ref_rd_ff - rpa_pkg::COUNT_BITS'(1) : ref_rd_ff;

   always_comb begin
      ref_we    = 1'b0;
      ref_waddr = rpa_pkg::IDX_W'(page_wide);
      ref_wdata = '0;
      stk_we    = 1'b0;
      stk_waddr = rpa_pkg::IDX_W'(depth_ff);
      stk_wdata = page_ff;
      depth_in  = depth_ff;
      walk_in   = walk_ff;
      rsp_in    = rsp_ff;

      if (cmd.clear_step) begin
         ref_we    = 1'b1;
         ref_waddr = rpa_pkg::IDX_W'(walk_ff);
         walk_in   = walk_ff + rpa_pkg::WIDE_W'(1);
      end

      if (cmd.walk_start) begin
         depth_in = '0;
         walk_in  = rpa_pkg::WIDE_W'(first_page);
      end

      if (cmd.walk_step) begin
         ref_we    = 1'b1;
         ref_waddr = rpa_pkg::IDX_W'(walk_ff);
         stk_we    = 1'b1;
         stk_wdata = rpa_pkg::PAGE_W'(walk_ff);
         depth_in  = depth_ff + rpa_pkg::DEPTH_W'(1);
         walk_in   = walk_ff + rpa_pkg::WIDE_W'(1);
      end

      if (cmd.commit) begin
         rsp_in.status    = rpa_pkg::STAT_OK;
         rsp_in.page_out  = '0;
         rsp_in.ref_count = '0;
         case (op_ff)
            rpa_pkg::OP_ALLOC: begin
               if (depth_ff == '0) begin
                  rsp_in.status = rpa_pkg::STAT_NO_PAGE;
               end else begin
                  depth_in         = depth_ff - rpa_pkg::DEPTH_W'(1);
                  ref_we           = pop_wide < rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES);
                  ref_waddr        = rpa_pkg::IDX_W'(pop_wide);
                  ref_wdata        = rpa_pkg::COUNT_BITS'(1);
                  rsp_in.page_out  = stk_rd_ff;
                  rsp_in.ref_count = rpa_pkg::REF_W'(1);
               end
            end
            rpa_pkg::OP_FREE: begin
               if (!in_range || below_first) begin
                  rsp_in.status = rpa_pkg::STAT_BAD_PAGE;
               end else begin
                  ref_we           = 1'b1;
                  ref_wdata        = dec_cnt;
                  rsp_in.ref_count = cap_count(dec_cnt);
                  if (dec_cnt == '0) begin
                     if (stack_full) begin
                        rsp_in.status = rpa_pkg::STAT_FULL;
                     end else begin
                        stk_we   = 1'b1;
                        depth_in = depth_ff + rpa_pkg::DEPTH_W'(1);
                     end
                  end
               end
            end
            rpa_pkg::OP_INC_REF, rpa_pkg::OP_DEC_REF, rpa_pkg::OP_GET_REF: begin
               if (!in_range) begin
                  rsp_in.status = rpa_pkg::STAT_BAD_PAGE;
               end else begin
                  ref_wdata = ref_rd_ff;
                  if (op_ff == rpa_pkg::OP_INC_REF) begin
                     ref_we    = 1'b1;
                     ref_wdata = inc_cnt;
                  end else if (op_ff == rpa_pkg::OP_DEC_REF) begin
                     ref_we    = 1'b1;
                     ref_wdata = dec_cnt;
                  end
                  rsp_in.ref_count = cap_count(ref_wdata);
               end
            end
            default: begin
               // Init, free-count query and the unused code report only the depth.
            end
         endcase
         rsp_in.free_count = rpa_pkg::FREE_W'(depth_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         walk_ff  <= '0;
      end else begin
         depth_ff <= depth_in;
         walk_ff  <= walk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req.opcode;
         page_ff <= req.page;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      if (cmd.load) begin
         ref_rd_ff <= ref_mem[ref_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.load) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign sts.op_init    = op_ff == rpa_pkg::OP_INIT;
   assign sts.clear_last = walk_ff == rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES - 1);
   assign sts.walk_done  = walk_ff >= rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES);
   assign rsp            = rsp_ff;

endmodule

// ===== rtl/rpa_ctrl.sv =====
// Controller state machine of the page allocator: handshakes and datapath commands.
module rpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  rpa_pkg::sts_type sts,
   output rpa_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;
   localparam logic [1:0] ST_WALK  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.op_init) begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (!sts.walk_done) begin
               cmd.walk_step = 1'b1;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/rpa_checker.sv =====
// Port-level checker of the page allocator and its bind to the top level.
module rpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rpa_pkg::rsp_type rsp_data
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The block never accepts transactions back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("transaction accepted on consecutive cycles");

   // An empty stack reports no page and no count.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == rpa_pkg::STAT_NO_PAGE |->
         rsp_data.page_out == '0 && rsp_data.ref_count == '0)
      else $error("failed alloc reported a page or count");

   // A handed-out page always comes with one reference and an ok status.
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.page_out != '0 |->
         rsp_data.ref_count == rpa_pkg::REF_W'(1) && rsp_data.status == rpa_pkg::STAT_OK)
      else $error("allocated page without a single reference");

   // The free stack never holds more than every page.
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rpa_pkg::WIDE_W'(rsp_data.free_count) <= rpa_pkg::WIDE_W'(rpa_pkg::NUM_PAGES))
      else $error("free count beyond the number of pages");

endmodule

bind refcounted_page_allocator_unit rpa_checker u_rpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/refcounted_page_allocator_unit_tb.sv =====
// Self-checking testbench for the reference-counted page allocator unit.
`timescale 1ns / 100ps

module refcounted_page_allocator_unit_tb;

   // Opcode 7 is not assigned to any operation; the block must leave its state untouched.
   localparam logic [rpa_pkg::OP_W-1:0] OP_UNUSED      = 3'd7;
   localparam logic [2:0]               CSR_FIRST_PAGE = 3'd0;
   localparam int                       COUNT_MAX      = (1 << rpa_pkg::COUNT_BITS) - 1;
   localparam int                       LAST_PAGE      = rpa_pkg::NUM_PAGES - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_ready;
   rpa_pkg::req_type req_data  = '0;

   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rpa_pkg::rsp_type rsp_data;

   logic             psel    = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite  = 1'b0;
   logic [2:0]       paddr   = '0;
   logic [31:0]      pwdata  = '0;
   logic [31:0]      prdata;
   logic             pready;

   refcounted_page_allocator_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------------
   // Predicted allocator state. It mirrors what the hardware holds: the free stack, its depth,
   // the per-page reference counts and the first_page register.
   // ------------------------------------------------------------------------------------------
   logic [rpa_pkg::PAGE_W-1:0] stack_model [rpa_pkg::NUM_PAGES];
   logic [rpa_pkg::REF_W-1:0]  page_refs   [rpa_pkg::NUM_PAGES] = '{default: '0};
   int                         free_depth     = 0;
   int                         first_page_cfg = 0;

   // Results that have been predicted for accepted transactions but not yet seen.
   rpa_pkg::rsp_type pending_results [$];

   int error_count = 0;
   int burst_left  = 0;
   int rsp_holdoff_cycles = 0;
   int ops_sent    [8] = '{default: 0};
   int status_seen [4] = '{default: 0};

   // Applies one operation to the predicted state and returns the result it should produce.
   function automatic rpa_pkg::rsp_type apply_operation(input rpa_pkg::req_type item);
      rpa_pkg::rsp_type r;
      int               p;
      r = '0;
      p = int'(item.page);
      case (item.opcode)
         rpa_pkg::OP_INIT: begin
            // Rebuild the stack from first_page upward; counts below first_page survive.
            free_depth = 0;
            for (int q = first_page_cfg; q < rpa_pkg::NUM_PAGES; q++) begin
               page_refs[q] = '0;
               stack_model[free_depth] = q[rpa_pkg::PAGE_W-1:0];
               free_depth++;
            end
         end
         rpa_pkg::OP_ALLOC: begin
            if (free_depth == 0) begin
               r.status = rpa_pkg::STAT_NO_PAGE;
            end else begin
               free_depth--;
               r.page_out = stack_model[free_depth];
               page_refs[r.page_out] = 8'd1;
               r.ref_count = 8'd1;
            end
         end
         rpa_pkg::OP_FREE: begin
            if (p < first_page_cfg) begin
               r.status = rpa_pkg::STAT_BAD_PAGE;
            end else begin
               if (page_refs[p] != 0) page_refs[p]--;
               // A page whose count is zero goes back on the stack, even if it was already free.
               if (page_refs[p] == 0) begin
                  if (free_depth >= rpa_pkg::NUM_PAGES) begin
                     r.status = rpa_pkg::STAT_FULL;
                  end else begin
                     stack_model[free_depth] = item.page;
                     free_depth++;
                  end
               end
               r.ref_count = page_refs[p];
            end
         end
         rpa_pkg::OP_INC_REF, rpa_pkg::OP_DEC_REF, rpa_pkg::OP_GET_REF: begin
            // Every 14-bit page is in range, and these operations ignore first_page.
            if (item.opcode == rpa_pkg::OP_INC_REF && page_refs[p] < COUNT_MAX)
               page_refs[p]++;
            else if (item.opcode == rpa_pkg::OP_DEC_REF && page_refs[p] > 0)
               page_refs[p]--;
            r.ref_count = page_refs[p];
         end
         default: ;
      endcase
      r.free_count = free_depth[rpa_pkg::FREE_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Sender. Transactions go out in bursts of random length separated by random gaps. The
   // prediction is made at the edge where the transaction is accepted, so the expected result
   // queue is always in acceptance order.
   // ------------------------------------------------------------------------------------------
   task automatic send_operation(input logic [rpa_pkg::OP_W-1:0] op,
                                 input logic [rpa_pkg::PAGE_W-1:0] page);
      rpa_pkg::req_type item;
      item.opcode = op;
      item.page   = page;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      pending_results.push_back(apply_operation(item));
      ops_sent[op]++;
   endtask

   // Stops offering transactions and waits until every predicted result has been seen. The last
   // write-back lands at the edge that loads the last result, so the extra cycles are only slack.
   task automatic wait_for_drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes first_page with a setup and an access phase, then reads it back the same way.
   task automatic write_first_page(input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_FIRST_PAGE;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      first_page_cfg = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[rpa_pkg::PAGE_W-1:0] !== value[rpa_pkg::PAGE_W-1:0])
         $error("first_page readback: expected %0d, actual %0d",
                value, prdata[rpa_pkg::PAGE_W-1:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------------------------
   // Receiver. rsp_ready follows stretches of random length, each with its own stall rate; some
   // stretches never stall. A test can request a long hold-off, which this process counts down.
   // ------------------------------------------------------------------------------------------
   initial begin : rsp_pacing
      int stretch;
      int stall_pct;
      forever begin
         stretch = $urandom_range(10, 80);
         case ($urandom_range(0, 3))
            0, 1:    stall_pct = 0;
            2:       stall_pct = 30;
            default: stall_pct = 75;
         endcase
         repeat (stretch) begin
            @(posedge clock);
            if (rsp_holdoff_cycles > 0) begin
               rsp_ready <= 1'b0;
               rsp_holdoff_cycles--;
            end else begin
               rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
         end
      end
   end

   // Checks every accepted result against the oldest prediction, field by field.
   always @(posedge clock) begin
      rpa_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("rsp_data: no result expected, actual %h", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            status_seen[rsp_data.status]++;
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.page_out !== want.page_out) begin
               $error("page_out: expected %0d, actual %0d", want.page_out, rsp_data.page_out);
               error_count++;
            end
            if (rsp_data.ref_count !== want.ref_count) begin
               $error("ref_count: expected %0d, actual %0d", want.ref_count, rsp_data.ref_count);
               error_count++;
            end
            if (rsp_data.free_count !== want.free_count) begin
               $error("free_count: expected %0d, actual %0d",
                      want.free_count, rsp_data.free_count);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------------------------

   // Every operation on a tiny pool: empty stack, unused opcode, counts below first_page that
   // survive init, double free, bad pages at both ends and draining the stack to empty.
   task automatic test_directed_operations();
      write_first_page(LAST_PAGE - 3);
      send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_GET_FREE, '0);
      send_operation(OP_UNUSED, 14'h3FFF);
      send_operation(rpa_pkg::OP_INC_REF, 14'd0);
      send_operation(rpa_pkg::OP_INIT, '0);
      send_operation(rpa_pkg::OP_GET_REF, 14'd0);
      send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_INC_REF, 14'h3FFF);
      send_operation(rpa_pkg::OP_GET_REF, 14'h3FFF);
      send_operation(rpa_pkg::OP_DEC_REF, 14'h3FFF);
      send_operation(rpa_pkg::OP_FREE, 14'h3FFF);
      send_operation(rpa_pkg::OP_FREE, 14'h3FFF);
      send_operation(rpa_pkg::OP_FREE, 14'd0);
      send_operation(rpa_pkg::OP_FREE, rpa_pkg::PAGE_W'(LAST_PAGE - 4));
      send_operation(rpa_pkg::OP_DEC_REF, 14'd0);
      send_operation(rpa_pkg::OP_DEC_REF, 14'd0);
      repeat (6) send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_GET_FREE, '0);
      wait_for_drain();
   endtask

   // first_page at both extremes: a full stack that drops a push, and a one-page pool.
   task automatic test_first_page_extremes();
      write_first_page(0);
      send_operation(rpa_pkg::OP_INIT, '0);
      send_operation(rpa_pkg::OP_FREE, 14'd100);
      send_operation(rpa_pkg::OP_GET_FREE, '0);
      send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_FREE, 14'h3FFF);
      send_operation(rpa_pkg::OP_FREE, 14'd7);
      wait_for_drain();
      write_first_page(LAST_PAGE);
      send_operation(rpa_pkg::OP_INIT, '0);
      send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_ALLOC, '0);
      send_operation(rpa_pkg::OP_FREE, rpa_pkg::PAGE_W'(LAST_PAGE - 1));
      send_operation(rpa_pkg::OP_FREE, rpa_pkg::PAGE_W'(LAST_PAGE));
      wait_for_drain();
   endtask

   // Pushes one count past its ceiling, then steps it down again.
   task automatic test_count_saturation();
      repeat (COUNT_MAX + 3) send_operation(rpa_pkg::OP_INC_REF, 14'd2);
      repeat (2) send_operation(rpa_pkg::OP_DEC_REF, 14'd2);
      send_operation(rpa_pkg::OP_GET_REF, 14'd2);
      wait_for_drain();
   endtask

   // Holds rsp_ready low long enough for the block to fill and stall its input, then pauses
   // the sender until every outstanding result has arrived.
   task automatic test_output_backpressure();
      rsp_holdoff_cycles = 300;
      repeat (30) begin
         case ($urandom_range(0, 3))
            0: send_operation(rpa_pkg::OP_ALLOC, '0);
            1: send_operation(rpa_pkg::OP_INC_REF,
                              rpa_pkg::PAGE_W'($urandom_range(LAST_PAGE, 0)));
            2: send_operation(rpa_pkg::OP_FREE,
                              rpa_pkg::PAGE_W'(LAST_PAGE - $urandom_range(0, 7)));
            default: send_operation(rpa_pkg::OP_GET_FREE, '0);
         endcase
      end
      wait_for_drain();
   endtask

   // Random traffic in phases. Each phase starts idle with a new first_page, usually rebuilt by
   // an init, and then mostly touches pages inside the pool so that allocs and frees interact.
   task automatic test_random_traffic();
      logic [rpa_pkg::PAGE_W-1:0] page;
      int                         pick;
      for (int phase = 0; phase < 7; phase++) begin
         if (phase == 3) write_first_page($urandom_range(16000, 12000));
         else            write_first_page($urandom_range(LAST_PAGE, LAST_PAGE - 127));
         if ($urandom_range(0, 3) != 0)
            send_operation(rpa_pkg::OP_INIT, rpa_pkg::PAGE_W'($urandom_range(LAST_PAGE, 0)));
         repeat (58) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: page = rpa_pkg::PAGE_W'(LAST_PAGE - $urandom_range(0, 15));
               4, 5, 6:    page = rpa_pkg::PAGE_W'($urandom_range(LAST_PAGE, first_page_cfg));
               default:    page = rpa_pkg::PAGE_W'($urandom_range(LAST_PAGE, 0));
            endcase
            pick = $urandom_range(0, 99);
            if      (pick < 28) send_operation(rpa_pkg::OP_ALLOC, page);
            else if (pick < 50) send_operation(rpa_pkg::OP_FREE, page);
            else if (pick < 62) send_operation(rpa_pkg::OP_INC_REF, page);
            else if (pick < 74) send_operation(rpa_pkg::OP_DEC_REF, page);
            else if (pick < 84) send_operation(rpa_pkg::OP_GET_REF, page);
            else if (pick < 90) send_operation(rpa_pkg::OP_GET_FREE, page);
            else if (pick < 95 && phase != 3) send_operation(rpa_pkg::OP_INIT, page);
            else                send_operation(OP_UNUSED, page);
         end
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_operations();
      test_first_page_extremes();
      test_count_saturation();
      test_output_backpressure();
      test_random_traffic();
      wait_for_drain();
      repeat (10) @(posedge clock);
      $display("Covered %0d init, %0d alloc, %0d free, %0d inc, %0d dec, %0d get_ref,",
               ops_sent[rpa_pkg::OP_INIT], ops_sent[rpa_pkg::OP_ALLOC],
               ops_sent[rpa_pkg::OP_FREE], ops_sent[rpa_pkg::OP_INC_REF],
               ops_sent[rpa_pkg::OP_DEC_REF], ops_sent[rpa_pkg::OP_GET_REF]);
      $display("%0d free-count and %0d unused-opcode transactions; %s %0d/%0d/%0d/%0d",
               ops_sent[rpa_pkg::OP_GET_FREE], ops_sent[OP_UNUSED],
               "status ok/empty/bad/full", status_seen[rpa_pkg::STAT_OK],
               status_seen[rpa_pkg::STAT_NO_PAGE], status_seen[rpa_pkg::STAT_BAD_PAGE],
               status_seen[rpa_pkg::STAT_FULL]);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including the clearing pass and the long inits.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
